### hdl/qrs_pkg.sv
// Shared constants, codes and helpers for the quadrant rotate/swap block.
// No dependencies; imported by the top level.
package qrs_pkg;

  // Largest quarter size and the region store that follows from it
  localparam int MAX_PIECE_W = 32;
  localparam int MAX_PIECE_H = 32;
  localparam int STORE_DEPTH = 4 * MAX_PIECE_W * MAX_PIECE_H;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int PIX_W  = 32;
  localparam int SIZE_W = 6;
  localparam int CFG_IDX_W = 2;

  // Item operation codes (carried in tuser)
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIECE_W   = 2'd0,
    CFG_PIECE_H   = 2'd1,
    CFG_SWAP_MODE = 2'd2
  } cfg_index_t;

  // Quarter arrangement modes
  localparam logic MODE_ROTATE = 1'b0;
  localparam logic MODE_SWAP   = 1'b1;

  // Saturate a written size into 1..hi
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/quadrant_rotate_swap_top.sv
// Quadrant rotate/swap top level: frame store, raster counters, output stage.
// Depends on qrs_pkg and qrs_ram.
//
// Usage:
//   The slave stream carries requests: tuser selects a load (0) or an emit
//   (1); tdata is the pixel, used by loads only. Loads fill the region of
//   2*piece_width by 2*piece_height pixels in raster order. Each emit yields
//   one pixel of the rearranged region on the master stream, in raster order,
//   with tlast on the final pixel of the region. Mode 0 rotates the quarters
//   clockwise, mode 1 swaps the diagonal quarters.
//   Configuration writes (cfg_we/cfg_index/cfg_data) to indexes 0 to 2 take
//   effect at once and return both raster positions to the start; the store
//   keeps its contents. Throughput: one request per cycle while the receiver
//   keeps up, set by the single read and write port of the store. An emitted
//   pixel passes the store read register and then the output register.
//   Reset (rst, synchronous) clears positions and sets piece sizes to 1 and
//   mode 0; the store is not cleared, so emit only entries already loaded.
//   When the receiver stalls, one result waits in the output register and
//   one in the store read register; s_tready then drops until space frees.
module quadrant_rotate_swap_top (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [qrs_pkg::PIX_W-1:0]      s_tdata,   // [31:0] pixel_in
  input  logic                           s_tuser,   // [0] operation
  // master stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [qrs_pkg::PIX_W-1:0]      m_tdata,   // [31:0] pixel_out
  output logic                           m_tlast,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [qrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qrs_pkg::SIZE_W-1:0]     cfg_data
);
  import qrs_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] piece_w, piece_h;
  logic              swap_mode;
  logic              cfg_hit;

  // Raster positions
  logic [ADDR_W-1:0] load_pos;
  logic [SIZE_W-1:0] emit_row, emit_col;

  // Read and output stages
  logic              rd_valid, rd_last;
  logic              out_valid, out_last;
  logic [PIX_W-1:0]  out_data;
  logic [PIX_W-1:0]  ram_rdata;

  // Handshake and derived geometry
  logic              rd_moves, accept, load_acc, emit_acc;
  logic [2*SIZE_W-1:0] area;
  logic [ADDR_W+1:0] region_last_full;
  logic [ADDR_W-1:0] region_last;
  logic [SIZE_W:0]   row_len, col_last_full, row_last_full;
  logic [SIZE_W-1:0] col_last, row_last;
  logic              top, left, at_last;
  logic [SIZE_W-1:0] src_row, src_col;
  logic [ADDR_W:0]   src_full;
  logic [ADDR_W-1:0] src_addr;

  assign rd_moves = !out_valid || m_tready;
  assign s_tready = !rd_valid || rd_moves;
  assign accept   = s_tvalid && s_tready;
  assign load_acc = accept && (s_tuser == OP_LOAD);
  assign emit_acc = accept && (s_tuser == OP_EMIT);

  // Region limits from the quarter size
  assign area             = (2*SIZE_W)'(piece_w) * (2*SIZE_W)'(piece_h);
  assign region_last_full = {area, 2'b00} - (ADDR_W+2)'(1);
  assign region_last      = region_last_full[ADDR_W-1:0];
  assign row_len          = {piece_w, 1'b0};
  assign col_last_full    = row_len - (SIZE_W+1)'(1);
  assign row_last_full    = {piece_h, 1'b0} - (SIZE_W+1)'(1);
  assign col_last         = col_last_full[SIZE_W-1:0];
  assign row_last         = row_last_full[SIZE_W-1:0];
  assign at_last          = (emit_row == row_last) && (emit_col == col_last);

  // Source pixel of the current output position
  assign top  = emit_row < piece_h;
  assign left = emit_col < piece_w;

  always_comb begin
    src_row = emit_row;
    src_col = emit_col;
    if (swap_mode == MODE_ROTATE) begin
      if (top && left) begin
        src_row = emit_row + piece_h;
      end else if (top) begin
        src_col = emit_col - piece_w;
      end else if (!left) begin
        src_row = emit_row - piece_h;
      end else begin
        src_col = emit_col + piece_w;
      end
    end else begin
      src_row = top  ? emit_row + piece_h : emit_row - piece_h;
      src_col = left ? emit_col + piece_w : emit_col - piece_w;
    end
  end

  assign src_full = (ADDR_W+1)'(src_row) * (ADDR_W+1)'(row_len) + (ADDR_W+1)'(src_col);
  assign src_addr = src_full[ADDR_W-1:0];

  // Region store
  qrs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (load_pos),
    .wdata (s_tdata),
    .re    (emit_acc),
    .raddr (src_addr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_comb begin
    unique case (cfg_index)
      CFG_PIECE_W, CFG_PIECE_H, CFG_SWAP_MODE: cfg_hit = cfg_we;
      default:                                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_w   <= SIZE_W'(1);
      piece_h   <= SIZE_W'(1);
      swap_mode <= MODE_ROTATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIECE_W:   piece_w   <= clamp_size(cfg_data, SIZE_W'(MAX_PIECE_W));
        CFG_PIECE_H:   piece_h   <= clamp_size(cfg_data, SIZE_W'(MAX_PIECE_H));
        CFG_SWAP_MODE: swap_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Load position: linear raster index, wraps at the region end
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_pos <= '0;
    end else if (load_acc) begin
      load_pos <= (load_pos == region_last) ? '0 : load_pos + ADDR_W'(1);
    end
  end

  // Emit position as row and column
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      emit_row <= '0;
      emit_col <= '0;
    end else if (emit_acc) begin
      if (emit_col == col_last) begin
        emit_col <= '0;
        emit_row <= (emit_row == row_last) ? '0 : emit_row + SIZE_W'(1);
      end else begin
        emit_col <= emit_col + SIZE_W'(1);
      end
    end
  end

  // Store read stage: data waits in the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (emit_acc) begin
      rd_valid <= 1'b1;
    end else if (rd_moves) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      rd_last <= at_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_valid && rd_moves) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && rd_moves) begin
      out_data <= ram_rdata;
      out_last <= rd_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  // Checks
  a_last_tagged: assert property (@(posedge clk) disable iff (rst)
    emit_acc && at_last |=> rd_valid && rd_last)
    else $error("final region pixel not tagged last");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> load_pos == '0 && emit_row == '0 && emit_col == '0)
    else $error("positions not restarted by register write");

  a_load_wrap: assert property (@(posedge clk) disable iff (rst)
    load_acc && !cfg_hit && load_pos == region_last |=> load_pos == '0)
    else $error("load position did not wrap at region end");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !rd_moves |=> rd_valid && $stable(ram_rdata) && $stable(rd_last))
    else $error("pending store read lost while output stalled");

endmodule

### hdl/qrs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered,
// enable-held read data. No dependencies.
module qrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sim/quadrant_rotate_swap_top_tb.sv
// Self-checking testbench for quadrant_rotate_swap_top: streams load/emit requests,
// predicts every rearranged pixel and checks it on the master stream.
// Depends on qrs_pkg and the quadrant_rotate_swap_top RTL.
`timescale 1ns / 100ps

module quadrant_rotate_swap_top_tb;
  import qrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_REQUESTS = 1500;

  typedef struct {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } pixel_request_t;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } pixel_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata = '0;   // [31:0] pixel_in
  logic             s_tuser = OP_LOAD;  // [0] operation
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;   // [31:0] pixel_out
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PIECE_W;
  logic [SIZE_W-1:0]    cfg_data = '0;

  // Request stream and pixels still owed by the block
  pixel_request_t pending_requests[$];
  pixel_result_t  pixels_due[$];
  pixel_request_t next_req;
  pixel_result_t  want;

  // Predicted block state
  logic [PIX_W-1:0] frame_mem[STORE_DEPTH];
  int unsigned      load_pos = 0;
  int unsigned      emit_pos = 0;
  int unsigned      piece_w = 1;
  int unsigned      piece_h = 1;
  logic             arrange_mode = MODE_ROTATE;

  // Generator bookkeeping: which entries hold data, where the next request lands
  bit               filled[STORE_DEPTH];
  int unsigned      gen_load = 0;
  int unsigned      gen_emit = 0;
  int unsigned      queued_count = 0;

  bit               pace_on = 1'b0;
  int               send_gap = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;
  int               failures = 0;

  quadrant_rotate_swap_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned region_pixels();
    return 4 * piece_w * piece_h;
  endfunction

  // Store entry feeding a given output raster position
  function automatic int unsigned source_index(int unsigned pos);
    int unsigned row_len, r, c, sr, sc;
    logic        top, left;
    row_len = 2 * piece_w;
    r = pos / row_len;
    c = pos % row_len;
    top = r < piece_h;
    left = c < piece_w;
    sr = r;
    sc = c;
    if (arrange_mode == MODE_ROTATE) begin
      if (top && left) sr = r + piece_h;       // from bottom-left
      else if (top) sc = c - piece_w;          // from top-left
      else if (!left) sr = r - piece_h;        // from top-right
      else sc = c + piece_w;                   // from bottom-right
    end else begin
      sr = top ? r + piece_h : r - piece_h;
      sc = left ? c + piece_w : c - piece_w;
    end
    return sr * row_len + sc;
  endfunction

  function automatic int unsigned next_pos(int unsigned pos);
    return (pos + 1 >= region_pixels()) ? 0 : pos + 1;
  endfunction

  // Update predicted state for one accepted request
  task automatic absorb_request(logic op, logic [PIX_W-1:0] pixel);
    pixel_result_t res;
    if (op == OP_LOAD) begin
      frame_mem[load_pos] = pixel;
      load_pos = next_pos(load_pos);
    end else begin
      res.pixel = frame_mem[source_index(emit_pos)];
      res.last = (emit_pos + 1 >= region_pixels());
      pixels_due.insert(pixels_due.size(), res);
      emit_pos = next_pos(emit_pos);
    end
  endtask

  task automatic queue_load(logic [PIX_W-1:0] pixel);
    pixel_request_t req;
    req.op = OP_LOAD;
    req.pixel = pixel;
    pending_requests.insert(pending_requests.size(), req);
    filled[gen_load] = 1'b1;
    gen_load = next_pos(gen_load);
    queued_count++;
  endtask

  task automatic queue_emit();
    pixel_request_t req;
    req.op = OP_EMIT;
    req.pixel = PIX_W'($urandom);
    pending_requests.insert(pending_requests.size(), req);
    gen_emit = next_pos(gen_emit);
    queued_count++;
  endtask

  function automatic bit emit_ready();
    return filled[source_index(gen_emit)];
  endfunction

  // Register write at the next edge; sizes saturate into 1..max
  task automatic write_reg(cfg_index_t idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PIECE_W:   piece_w = (val == 0) ? 1 : (val > MAX_PIECE_W) ? MAX_PIECE_W : val;
      CFG_PIECE_H:   piece_h = (val == 0) ? 1 : (val > MAX_PIECE_H) ? MAX_PIECE_H : val;
      CFG_SWAP_MODE: arrange_mode = val[0];
      default: ;
    endcase
    load_pos = 0;
    emit_pos = 0;
    gen_load = 0;
    gen_emit = 0;
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic mode);
    write_reg(CFG_PIECE_W, w);
    write_reg(CFG_PIECE_H, h);
    write_reg(CFG_SWAP_MODE, SIZE_W'(mode));
    close_writes();
  endtask

  // Wait until everything is accepted and returned, then let the pipeline empty
  task automatic settle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || pixels_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Whole frames: loads with emits mixed in wherever the source is already loaded
  task automatic build_frames(int unsigned frames);
    int unsigned n, loads, emits;
    n = region_pixels();
    repeat (frames) begin
      loads = 0;
      emits = 0;
      while (loads < n || emits < n) begin
        if (emits < n && (loads == n || $urandom_range(0, 1) == 1) && emit_ready()) begin
          queue_emit();
          emits++;
        end else if (loads < n) begin
          queue_load(PIX_W'($urandom));
          loads++;
        end
      end
    end
  endtask

  // Random mix; an emit that would read an unloaded entry becomes a load
  task automatic build_noise(int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 1 && emit_ready()) queue_emit();
      else queue_load(PIX_W'($urandom));
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_request(s_tuser, s_tdata);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_req.op;
          s_tdata <= next_req.pixel;
          if (pace_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel_out arrived with nothing outstanding: actual %h", m_tdata);
          failures++;
        end else begin
          want = pixels_due.pop_front();
          if (m_tdata !== want.pixel) begin
            $error("pixel_out mismatch: expected %h actual %h", want.pixel, m_tdata);
            failures++;
          end
          if (m_tlast !== want.last) begin
            $error("last_pixel mismatch: expected %b actual %b", want.last, m_tlast);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (pace_on && $urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 6);
      end
    end
  end

  // Watchdog: too long with no request and no pixel moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned wr, hr, goal;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    pace_on = 1'b1;

    // Reset sizes (1x1), rotate: extreme pixels, emit past the end to see the wrap
    queue_load(32'h0000_0000);
    queue_load(32'hFFFF_FFFF);
    queue_load(32'h5555_5555);
    queue_load(32'hAAAA_AAAA);
    repeat (5) queue_emit();
    queue_load(32'h8000_0001);
    repeat (3) queue_emit();
    settle();

    // Mode change alone: positions restart, store contents kept
    write_reg(CFG_SWAP_MODE, SIZE_W'(MODE_SWAP));
    close_writes();
    repeat (4) queue_emit();
    settle();

    // Zero sizes saturate to one
    configure('0, '0, MODE_ROTATE);
    repeat (4) queue_emit();
    settle();

    // Oversized writes saturate to the largest quarter; one frame for each side
    configure('1, SIZE_W'(1), logic'($urandom_range(0, 1)));
    build_frames(1);
    settle();
    configure(SIZE_W'(1), '1, logic'($urandom_range(0, 1)));
    build_frames(1);
    settle();

    // Random phases, mostly small regions
    goal = queued_count + RANDOM_REQUESTS;
    while (queued_count < goal) begin
      pace_on = (goal - queued_count > 300) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0: begin wr = $urandom_range(5, 32); hr = $urandom_range(0, 2); end
        1: begin wr = $urandom_range(0, 2); hr = $urandom_range(5, 32); end
        2: begin wr = $urandom_range(33, 63); hr = 1; end
        default: begin wr = $urandom_range(0, 4); hr = $urandom_range(0, 4); end
      endcase
      configure(SIZE_W'(wr), SIZE_W'(hr), logic'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0) begin
        build_frames($urandom_range(1, 2));
        if ($urandom_range(0, 2) == 0) build_noise($urandom_range(1, region_pixels()));
      end else begin
        build_noise($urandom_range(region_pixels(), 2 * region_pixels()));
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (failures == 0 && pixels_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
